// ===== rtl/lis_pkg.sv =====
// Package for the longest increasing subsequence block: sizes, widths and
// the sequencer state type. No dependencies.
package lis_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int VALUE_BITS = 32;
   localparam int IDX_W      = $clog2(MAX_ITEMS);
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOP,
      ST_SEARCH,
      ST_PREV,
      ST_COMMIT,
      ST_LAUNCH,
      ST_WALK,
      ST_EMIT
   } lis_state_type;

endpackage

// ===== rtl/lis_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/longest_increasing_subsequence_top.sv =====
// Longest strictly increasing subsequence: tails table with binary search,
// backward rebuild and in-order emission. Uses lis_pkg and lis_ram.
//
//   channel   ports                                      transfer when
//   request   start, busy, req_value, req_last_item      start && !busy
//   result    rsp_strobe, rsp_subseq_length,             rsp_strobe (one cycle)
//             rsp_element_value, rsp_last_of_run, rsp_overflow
//
// busy stays high while an item that starts the tails table passes through commit, while one that
// equals or extends the last tail or lands below a lone tail passes through top and commit, and
// otherwise through top, binary search and, unless the slot found is 0, prev: one tails RAM read per search step.
// A last item adds a launch step, a backward walk from the best index towards item 0 and the
// emission of the elements, each result registered; a dropped item that is not last
// leaves busy low. Reset is synchronous and clears state and counters; no stall on results.
module longest_increasing_subsequence_top
   import lis_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         req_last_item,
   output logic                         rsp_strobe,
   output logic [CNT_W-1:0]             rsp_subseq_length,
   output logic signed [VALUE_BITS-1:0] rsp_element_value,
   output logic                         rsp_last_of_run,
   output logic                         rsp_overflow
);

   lis_state_type state_ff, state_in;

   logic [CNT_W-1:0] item_count_ff, item_count_in;
   logic [CNT_W-1:0] tail_count_ff, tail_count_in;
   logic [IDX_W-1:0] best_index_ff, best_index_in;
   logic [CNT_W-1:0] best_level_ff, best_level_in;
   logic             dropped_ff, dropped_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;

   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] level_ff, level_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             tail_wr_ff, tail_wr_in;
   logic             grow_ff, grow_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] found_ff, found_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [IDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0] walk_left_ff, walk_left_in;
   logic [CNT_W-1:0] walk_j_ff, walk_j_in;
   logic             walk_pend_ff, walk_pend_in;
   logic [CNT_W-1:0] emit_k_ff, emit_k_in;
   logic [CNT_W-1:0] rsp_len_ff, rsp_len_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   // RAM ports
   logic                  tail_wr_en;
   logic [IDX_W-1:0]      tail_rd_addr;
   logic [VALUE_BITS-1:0] tail_rd_data;
   logic                  val_wr_en;
   logic [VALUE_BITS-1:0] val_rd_data;
   logic                  lvl_wr_en;
   logic [CNT_W-1:0]      lvl_rd_data;
   logic                  chain_wr_en;
   logic [IDX_W-1:0]      chain_wr_addr;
   logic [IDX_W-1:0]      chain_rd_addr;
   logic [VALUE_BITS-1:0] chain_rd_data;

   // shared compare unit
   logic signed [VALUE_BITS-1:0] tail_s;
   logic             key_lt, key_eq;
   logic [IDX_W-1:0] s_lo_n, s_hi_n, s_found_n;
   logic [IDX_W:0]   s_sum;
   logic [IDX_W-1:0] s_mid_n;
   logic [IDX_W-1:0] top_hi;
   logic             accept, full;
   logic             walk_issue, walk_match;
   logic [CNT_W-1:0] walk_j_n;
   logic             emit_issue;

   assign accept = start && !busy;
   assign full   = (item_count_ff == CNT_W'(MAX_ITEMS));
   assign tail_s = $signed(tail_rd_data);
   assign key_lt = value_ff < tail_s;
   assign key_eq = value_ff == tail_s;
   assign top_hi = IDX_W'(tail_count_ff - CNT_W'(1));

   always_comb begin
      if (key_lt) begin
         s_lo_n    = lo_ff;
         s_hi_n    = mid_ff;
         s_found_n = mid_ff;
      end else begin
         s_lo_n    = mid_ff + IDX_W'(1);
         s_hi_n    = hi_ff;
         s_found_n = found_ff;
      end
      s_sum   = {1'b0, s_lo_n} + {1'b0, s_hi_n};
      s_mid_n = s_sum[IDX_W:1];
   end

   assign walk_issue = (walk_left_ff != '0);
   assign walk_match = walk_pend_ff && (lvl_rd_data == walk_j_ff);
   assign walk_j_n   = walk_match ? walk_j_ff - CNT_W'(1) : walk_j_ff;
   assign emit_issue = (emit_k_ff < rsp_len_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (full) begin
                  state_in = req_last_item ? ST_LAUNCH : ST_IDLE;
               end else if (tail_count_ff == '0) begin
                  state_in = ST_COMMIT;
               end else begin
                  state_in = ST_TOP;
               end
            end
         end
         ST_TOP: begin
            if (!key_lt || top_hi == '0) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (s_lo_n < s_hi_n) begin
               state_in = ST_SEARCH;
            end else if (s_found_n == '0) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_PREV;
            end
         end
         ST_PREV:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = last_ff ? ST_LAUNCH : ST_IDLE;
         ST_LAUNCH: state_in = (best_level_ff == '0) ? ST_IDLE : ST_WALK;
         ST_WALK: begin
            if (walk_j_n == '0 || !walk_issue) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!emit_issue || emit_k_ff + CNT_W'(1) == rsp_len_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      item_count_in = item_count_ff;
      tail_count_in = tail_count_ff;
      best_index_in = best_index_ff;
      best_level_in = best_level_ff;
      dropped_in    = dropped_ff;
      value_in      = value_ff;
      last_in       = last_ff;
      level_in      = level_ff;
      pos_in        = pos_ff;
      tail_wr_in    = tail_wr_ff;
      grow_in       = grow_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      found_in      = found_ff;
      mid_in        = mid_ff;
      walk_idx_in   = walk_idx_ff;
      walk_left_in  = walk_left_ff;
      walk_j_in     = walk_j_ff;
      walk_pend_in  = 1'b0;
      emit_k_in     = emit_k_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_valid_in  = 1'b0;
      rsp_last_in   = 1'b0;
      tail_wr_en    = 1'b0;
      tail_rd_addr  = mid_ff;
      val_wr_en     = 1'b0;
      lvl_wr_en     = 1'b0;
      chain_wr_en   = 1'b0;
      chain_wr_addr = IDX_W'(walk_j_ff - CNT_W'(1));
      chain_rd_addr = emit_k_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in     = req_value;
               last_in      = req_last_item;
               grow_in      = 1'b0;
               tail_wr_in   = 1'b0;
               tail_rd_addr = top_hi;
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  val_wr_en = 1'b1;
                  if (tail_count_ff == '0) begin
                     level_in   = CNT_W'(1);
                     pos_in     = '0;
                     tail_wr_in = 1'b1;
                     grow_in    = 1'b1;
                  end
               end
            end
         end
         ST_TOP: begin
            if (key_eq) begin
               level_in = '0;
            end else if (!key_lt) begin
               pos_in     = tail_count_ff[IDX_W-1:0];
               level_in   = tail_count_ff + CNT_W'(1);
               tail_wr_in = 1'b1;
               grow_in    = 1'b1;
            end else if (top_hi == '0) begin
               pos_in     = '0;
               level_in   = CNT_W'(1);
               tail_wr_in = 1'b1;
            end else begin
               lo_in        = '0;
               hi_in        = top_hi;
               found_in     = top_hi;
               mid_in       = top_hi >> 1;
               tail_rd_addr = top_hi >> 1;
            end
         end
         ST_SEARCH: begin
            lo_in    = s_lo_n;
            hi_in    = s_hi_n;
            found_in = s_found_n;
            if (s_lo_n < s_hi_n) begin
               mid_in       = s_mid_n;
               tail_rd_addr = s_mid_n;
            end else begin
               pos_in       = s_found_n;
               tail_rd_addr = s_found_n - IDX_W'(1);
               if (s_found_n == '0) begin
                  level_in   = CNT_W'(1);
                  tail_wr_in = 1'b1;
               end
            end
         end
         ST_PREV: begin
            if (key_eq) begin
               level_in = '0;
            end else begin
               level_in   = CNT_W'(pos_ff) + CNT_W'(1);
               tail_wr_in = 1'b1;
            end
         end
         ST_COMMIT: begin
            tail_wr_en    = tail_wr_ff;
            lvl_wr_en     = 1'b1;
            item_count_in = item_count_ff + CNT_W'(1);
            if (grow_ff) begin
               tail_count_in = tail_count_ff + CNT_W'(1);
            end
            if (item_count_ff == '0 || level_ff > best_level_ff) begin
               best_index_in = item_count_ff[IDX_W-1:0];
               best_level_in = level_ff;
            end
         end
         ST_LAUNCH: begin
            rsp_len_in    = best_level_ff;
            rsp_ovf_in    = dropped_ff;
            walk_idx_in   = best_index_ff;
            walk_left_in  = CNT_W'(best_index_ff) + CNT_W'(1);
            walk_j_in     = best_level_ff;
            emit_k_in     = '0;
            item_count_in = '0;
            tail_count_in = '0;
            best_index_in = '0;
            best_level_in = '0;
            dropped_in    = 1'b0;
         end
         ST_WALK: begin
            if (walk_issue) begin
               walk_idx_in  = walk_idx_ff - IDX_W'(1);
               walk_left_in = walk_left_ff - CNT_W'(1);
               walk_pend_in = 1'b1;
            end
            chain_wr_en = walk_match;
            walk_j_in   = walk_j_n;
         end
         ST_EMIT: begin
            if (emit_issue) begin
               emit_k_in    = emit_k_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_last_in  = (emit_k_ff + CNT_W'(1) == rsp_len_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         item_count_ff <= '0;
         tail_count_ff <= '0;
         best_index_ff <= '0;
         best_level_ff <= '0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         walk_pend_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_count_ff <= item_count_in;
         tail_count_ff <= tail_count_in;
         best_index_ff <= best_index_in;
         best_level_ff <= best_level_in;
         dropped_ff    <= dropped_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
         walk_pend_ff  <= walk_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      last_ff      <= last_in;
      level_ff     <= level_in;
      pos_ff       <= pos_in;
      tail_wr_ff   <= tail_wr_in;
      grow_ff      <= grow_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      found_ff     <= found_in;
      mid_ff       <= mid_in;
      walk_idx_ff  <= walk_idx_in;
      walk_left_ff <= walk_left_in;
      walk_j_ff    <= walk_j_in;
      emit_k_ff    <= emit_k_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   lis_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_tails (
      .clock   (clock),
      .wr_en   (tail_wr_en),
      .wr_addr (pos_ff),
      .wr_data (value_ff),
      .rd_addr (tail_rd_addr),
      .rd_data (tail_rd_data)
   );

   lis_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_values (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (item_count_ff[IDX_W-1:0]),
      .wr_data (req_value),
      .rd_addr (walk_idx_ff),
      .rd_data (val_rd_data)
   );

   lis_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ITEMS)) u_levels (
      .clock   (clock),
      .wr_en   (lvl_wr_en),
      .wr_addr (item_count_ff[IDX_W-1:0]),
      .wr_data (level_ff),
      .rd_addr (walk_idx_ff),
      .rd_data (lvl_rd_data)
   );

   lis_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_chain (
      .clock   (clock),
      .wr_en   (chain_wr_en),
      .wr_addr (chain_wr_addr),
      .wr_data (val_rd_data),
      .rd_addr (chain_rd_addr),
      .rd_data (chain_rd_data)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_subseq_length = rsp_len_ff;
   assign rsp_element_value = $signed(chain_rd_data);
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_overflow      = rsp_ovf_ff;

   a_tails_bounded: assert property (@(posedge clock) disable iff (reset)
      tail_count_ff <= item_count_ff)
      else $error("tail count exceeds item count");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> lo_ff < hi_ff)
      else $error("binary search entered with empty window");

   a_last_marks_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_run |-> rsp_strobe)
      else $error("end of run flagged without a transfer");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_run |=> !rsp_strobe)
      else $error("transfer after end of run");

   a_no_empty_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_subseq_length != '0)
      else $error("result with zero length");

endmodule

// ===== bench/longest_increasing_subsequence_top_test.sv =====
// Testbench for longest_increasing_subsequence_top: queued sequences are driven with
// random gaps, and every emitted element is checked against a predictor of the tails
// search and backward rebuild. Depends on lis_pkg and the block's RTL.
`timescale 1ns / 1ps

module longest_increasing_subsequence_top_test;
   import lis_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 111;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         last;
   } seq_item_type;

   typedef struct packed {
      logic [CNT_W-1:0]             length;
      logic signed [VALUE_BITS-1:0] value;
      logic                         last_of_run;
      logic                         overflow;
   } subseq_elem_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [VALUE_BITS-1:0] req_value;
   logic                         req_last_item;
   logic                         rsp_strobe;
   logic [CNT_W-1:0]             rsp_subseq_length;
   logic signed [VALUE_BITS-1:0] rsp_element_value;
   logic                         rsp_last_of_run;
   logic                         rsp_overflow;

   seq_item_type    pending_items[$];
   subseq_elem_type expected_elems[$];
   logic         req_taken;
   int           gap_left;
   int           queued_count;
   int           accepted_count;
   int           error_count;
   int           cycle_count;

   // predictor state
   logic signed [VALUE_BITS-1:0] seen_values[MAX_ITEMS];
   int                           seen_levels[MAX_ITEMS];
   logic signed [VALUE_BITS-1:0] tail_vals[MAX_ITEMS];
   int                           n_tails;
   int                           best_pos;
   int                           n_stored;
   logic                         dropped;

   longest_increasing_subsequence_top u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_value         (req_value),
      .req_last_item     (req_last_item),
      .rsp_strobe        (rsp_strobe),
      .rsp_subseq_length (rsp_subseq_length),
      .rsp_element_value (rsp_element_value),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_overflow      (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic predict_subseq(input logic signed [VALUE_BITS-1:0] v, input logic last);
      int lo, hi, mid, pos, lvl, idx, len, j, i, k;
      logic signed [VALUE_BITS-1:0] chain[MAX_ITEMS];
      subseq_elem_type e;
      if (n_stored < MAX_ITEMS) begin
         idx = n_stored;
         lvl = 0;
         seen_values[idx] = v;
         if (n_tails == 0) begin
            tail_vals[0] = v;
            n_tails = 1;
            lvl = 1;
         end else if (v == tail_vals[n_tails-1]) begin
            lvl = 0;
         end else if (v > tail_vals[n_tails-1]) begin
            tail_vals[n_tails] = v;
            n_tails++;
            lvl = n_tails;
         end else begin
            lo = 0;
            hi = n_tails;
            pos = n_tails;
            while (lo < hi) begin
               mid = lo + (hi - lo) / 2;
               if (v < tail_vals[mid]) begin
                  pos = mid;
                  hi = mid;
               end else begin
                  lo = mid + 1;
               end
            end
            if (pos > 0 && tail_vals[pos-1] == v) begin
               lvl = 0;
            end else begin
               tail_vals[pos] = v;
               lvl = pos + 1;
            end
         end
         seen_levels[idx] = lvl;
         if (idx == 0) best_pos = 0;
         else if (lvl > seen_levels[best_pos]) best_pos = idx;
         n_stored++;
      end else begin
         dropped = 1'b1;
      end
      if (last && n_stored > 0) begin
         len = seen_levels[best_pos];
         chain[len-1] = seen_values[best_pos];
         j = len - 1;
         for (i = best_pos - 1; i >= 0 && j > 0; i--) begin
            if (seen_levels[i] == j) begin
               chain[j-1] = seen_values[i];
               j--;
            end
         end
         for (k = 0; k < len; k++) begin
            e.length      = len[CNT_W-1:0];
            e.value       = chain[k];
            e.last_of_run = (k + 1 == len);
            e.overflow    = dropped;
            expected_elems.push_back(e);
         end
         n_tails  = 0;
         best_pos = 0;
         n_stored = 0;
         dropped  = 1'b0;
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      else if (r < 85) return $urandom_range(3, 1);
      else if (r < 97) return $urandom_range(10, 4);
      else return $urandom_range(40, 20);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value(int mode, int k, int base);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(16) - 8;
         2: return base + k * 16 + $urandom_range(24) - 12;
         default: begin
            case ($urandom_range(5))
               0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
               1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
               2: return '0;
               3: return '1;
               4: return 1;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   task automatic queue_item(input logic signed [VALUE_BITS-1:0] v, input logic last);
      seq_item_type it;
      it.value = v;
      it.last  = last;
      pending_items.push_back(it);
      queued_count++;
   endtask

   task automatic queue_sequence(input int n, input int mode, inout int count);
      int base, k;
      base = $urandom;
      for (k = 0; k < n; k++) queue_item(pick_value(mode, k, base), k == n - 1);
      count += n;
   endtask

   // driver: a new item is presented once the current one has transferred
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_value     <= pending_items[0].value;
            req_last_item <= pending_items[0].last;
            void'(pending_items.pop_front());
            start    <= 1'b1;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results checked against the oldest expectation, transfers predicted
   always @(posedge clock) begin
      subseq_elem_type e;
      req_taken <= start && !busy && !reset;
      if (!reset && rsp_strobe) begin
         if (expected_elems.size() == 0) begin
            $display("%0t: result with none expected: length %0d value %0d last %0b ovf %0b",
                     $time, rsp_subseq_length, rsp_element_value, rsp_last_of_run,
                     rsp_overflow);
            error_count++;
         end else begin
            e = expected_elems.pop_front();
            if (rsp_subseq_length !== e.length) begin
               $display("%0t: subseq_length expected %0d actual %0d",
                        $time, e.length, rsp_subseq_length);
               error_count++;
            end
            if (rsp_element_value !== e.value) begin
               $display("%0t: element_value expected %0d actual %0d",
                        $time, e.value, rsp_element_value);
               error_count++;
            end
            if (rsp_last_of_run !== e.last_of_run) begin
               $display("%0t: last_of_run expected %0b actual %0b",
                        $time, e.last_of_run, rsp_last_of_run);
               error_count++;
            end
            if (rsp_overflow !== e.overflow) begin
               $display("%0t: overflow expected %0b actual %0b",
                        $time, e.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
      if (!reset && start && !busy) begin
         predict_subseq(req_value, req_last_item);
         accepted_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_elems.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int rand_count, n, mode;
      reset         = 1'b1;
      start         = 1'b0;
      req_value     = '0;
      req_last_item = 1'b0;
      req_taken     = 1'b0;
      gap_left      = 0;
      queued_count  = 0;
      accepted_count = 0;
      error_count   = 0;
      cycle_count   = 0;
      n_tails       = 0;
      best_pos      = 0;
      n_stored      = 0;
      dropped       = 1'b0;
      rand_count    = 0;

      // single items at the extremes
      queue_item({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b1);
      queue_item({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b1);
      // equal to top tail, equal to tail below search position, extremes inside
      queue_item(5, 1'b0);
      queue_item(1, 1'b0);
      queue_item(8, 1'b0);
      queue_item(3, 1'b0);
      queue_item(9, 1'b0);
      queue_item(3, 1'b0);
      queue_item(9, 1'b0);
      queue_item({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b0);
      queue_item(-1, 1'b0);
      queue_item({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b1);
      // strictly decreasing: first item stays best
      queue_item(3, 1'b0);
      queue_item(2, 1'b0);
      queue_item(1, 1'b0);
      queue_item(0, 1'b1);
      // all equal
      queue_item(7, 1'b0);
      queue_item(7, 1'b0);
      queue_item(7, 1'b1);

      // beyond capacity, last mark on a dropped item
      queue_sequence(MAX_ITEMS + $urandom_range(6, 1), 2, rand_count);
      while (rand_count < RANDOM_ITEMS) begin
         mode = $urandom_range(3);
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
         if (n > RANDOM_ITEMS - rand_count) n = RANDOM_ITEMS - rand_count;
         queue_sequence(n, mode, rand_count);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (accepted_count == queued_count);
      wait (expected_elems.size() == 0 && !busy);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
